// ===== hdl/ffir_pkg.sv =====
// Shared types, codes and sizes for the first-fit interval reserver.
package ffir_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CNT_OUT_W   = 7;
  localparam int MIN_W       = 11;
  localparam int END_W       = 12;
  localparam int STEP_W      = 6;
  localparam int SUM_W       = 17;
  localparam int ROW_W       = 2 * MIN_W;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;

  localparam logic [1:0] CMD_RESERVE = 2'd0;
  localparam logic [1:0] CMD_CLEAR   = 2'd1;
  localparam logic [1:0] CMD_CHANGE  = 2'd2;

  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_NO_FIT    = 3'd1;
  localparam logic [2:0] STS_ZERO_DUR  = 3'd2;
  localparam logic [2:0] STS_FULL      = 3'd3;
  localparam logic [2:0] STS_BAD_INDEX = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_STEP  = 2'd2;

  localparam logic [MIN_W-1:0]  RST_WINDOW_START = 11'd540;
  localparam logic [MIN_W-1:0]  RST_WINDOW_END   = 11'd1020;
  localparam logic [STEP_W-1:0] RST_SEARCH_STEP  = 6'd5;

  typedef struct packed {
    logic [1:0]       command;
    logic [MIN_W-1:0] duration;
    logic [5:0]       entry_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [MIN_W-1:0]     start_minute;
    logic [END_W-1:0]     end_minute;
    logic [5:0]           slot_number;
    logic [CNT_OUT_W-1:0] count_now;
    logic [SUM_W-1:0]     total_reserved;
  } out_result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CHANGE
  } state_t;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_BLANK,
    OUT_RESERVE,
    OUT_CHANGE
  } out_kind_t;

  typedef struct packed {
    logic      load;
    logic      clear;
    logic      adv;
    logic      next;
    out_kind_t kind;
    logic [2:0] status;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] in_command;
    logic       in_dur_zero;
    logic       in_idx_bad;
    logic       full;
    logic       dur_zero;
    logic       over;
    logic       hit;
    logic       fits;
  } dp_sts_t;

endpackage

// ===== hdl/ffir_ctrl.sv =====
// Controller state machine: sequences reserve searches and entry changes.
module ffir_ctrl import ffir_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  dp_sts_t  sts,
  output ctl_cmd_t ctl
);

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (sts.in_command == CMD_RESERVE && !sts.in_dur_zero && !sts.full) begin
            state_nxt = ST_SEARCH;
          end else if (sts.in_command == CMD_CHANGE && !sts.in_idx_bad) begin
            state_nxt = ST_CHANGE;
          end
        end
      end
      ST_SEARCH: begin
        if (sts.over || sts.fits) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CHANGE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl = '{load: 1'b0, clear: 1'b0, adv: 1'b0, next: 1'b0,
            kind: OUT_NONE, status: STS_OK};
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ctl.load = 1'b1;
          case (sts.in_command)
            CMD_RESERVE: begin
              if (sts.in_dur_zero) begin
                ctl.kind   = OUT_BLANK;
                ctl.status = STS_ZERO_DUR;
              end else if (sts.full) begin
                ctl.kind   = OUT_BLANK;
                ctl.status = STS_FULL;
              end
            end
            CMD_CLEAR: begin
              ctl.clear = 1'b1;
              ctl.kind  = OUT_BLANK;
            end
            CMD_CHANGE: begin
              if (sts.in_idx_bad) begin
                ctl.kind   = OUT_BLANK;
                ctl.status = STS_BAD_INDEX;
              end
            end
            default: begin
              ctl.kind = OUT_BLANK;
            end
          endcase
        end
      end
      ST_SEARCH: begin
        if (sts.over) begin
          ctl.kind   = OUT_BLANK;
          ctl.status = STS_NO_FIT;
        end else if (sts.fits) begin
          ctl.kind = OUT_RESERVE;
        end else if (sts.hit) begin
          ctl.adv = 1'b1;
        end else begin
          ctl.next = 1'b1;
        end
      end
      ST_CHANGE: begin
        ctl.kind   = OUT_CHANGE;
        ctl.status = sts.dur_zero ? STS_ZERO_DUR : STS_OK;
      end
      default: begin
        ctl.kind = OUT_NONE;
      end
    endcase
  end

endmodule

// ===== hdl/ffir_dpath.sv =====
// Datapath: settings, interval table, candidate search and result registers.
module ffir_dpath import ffir_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  in_item_t              in_item,
  input  ctl_cmd_t              ctl,
  output dp_sts_t               sts,
  output out_result_t           out_result,
  output logic                  out_valid
);

  logic [ROW_W-1:0] mem [MAX_ENTRIES];
  logic [ROW_W-1:0] rd_r;

  logic [MIN_W-1:0]  win_start_r;
  logic [MIN_W-1:0]  win_end_r;
  logic [STEP_W-1:0] step_r;

  logic [MIN_W-1:0] dur_r;
  logic [END_W-1:0] cand_r, cand_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] clean_r, clean_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;

  logic             out_valid_r;
  logic [2:0]       status_r;
  logic [MIN_W-1:0] start_r, start_nxt;
  logic [END_W-1:0] end_r, end_nxt;
  logic [5:0]       slot_r, slot_nxt;

  logic [STEP_W-1:0] step_eff;
  logic [END_W:0]    cand_end;
  logic [MIN_W-1:0]  ob;
  logic [MIN_W-1:0]  ln;
  logic [END_W-1:0]  oe;
  logic              chg_write;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  logic [ROW_W-1:0]  mem_wd;

  assign step_eff = (step_r == '0) ? STEP_W'(1) : step_r;
  assign cand_end = (END_W + 1)'(cand_r) + (END_W + 1)'(dur_r);
  assign ob       = rd_r[ROW_W-1:MIN_W];
  assign ln       = rd_r[MIN_W-1:0];
  assign oe       = END_W'(ob) + END_W'(ln);
  assign chg_write = (ctl.kind == OUT_CHANGE) && (dur_r != '0);

  always_comb begin
    sts.in_command  = in_item.command;
    sts.in_dur_zero = (in_item.duration == '0);
    sts.in_idx_bad  = (int'(in_item.entry_index) >= int'(count_r));
    sts.full        = (count_r >= CNT_W'(MAX_ENTRIES));
    sts.dur_zero    = (dur_r == '0);
    sts.over        = (cand_end > (END_W + 1)'(win_end_r));
    sts.hit         = !((cand_end <= (END_W + 1)'(ob)) || (cand_r >= oe));
    sts.fits        = (clean_r == count_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_start_r <= RST_WINDOW_START;
      win_end_r   <= RST_WINDOW_END;
      step_r      <= RST_SEARCH_STEP;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_START: win_start_r <= cfg_data;
        CFG_WINDOW_END:   win_end_r   <= cfg_data;
        CFG_SEARCH_STEP:  step_r      <= cfg_data[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    ptr_nxt   = ptr_r;
    clean_nxt = clean_r;
    cand_nxt  = cand_r;
    if (ctl.load) begin
      ptr_nxt   = (in_item.command == CMD_CHANGE) ? IDX_W'(in_item.entry_index) : '0;
      clean_nxt = '0;
      cand_nxt  = END_W'(win_start_r);
    end else if (ctl.adv) begin
      clean_nxt = '0;
      cand_nxt  = cand_r + END_W'(step_eff);
    end else if (ctl.next) begin
      clean_nxt = clean_r + CNT_W'(1);
      if (CNT_W'(ptr_r) + CNT_W'(1) == count_r) begin
        ptr_nxt = '0;
      end else begin
        ptr_nxt = ptr_r + IDX_W'(1);
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    sum_nxt   = sum_r;
    if (ctl.clear) begin
      count_nxt = '0;
      sum_nxt   = '0;
    end else if (ctl.kind == OUT_RESERVE) begin
      count_nxt = count_r + CNT_W'(1);
      sum_nxt   = sum_r + SUM_W'(dur_r);
    end else if (chg_write) begin
      sum_nxt   = sum_r + SUM_W'(dur_r) - SUM_W'(ln);
    end
  end

  always_comb begin
    start_nxt = '0;
    end_nxt   = '0;
    slot_nxt  = '0;
    mem_we    = 1'b0;
    mem_wa    = ptr_r;
    mem_wd    = {ob, dur_r};
    case (ctl.kind)
      OUT_RESERVE: begin
        start_nxt = cand_r[MIN_W-1:0];
        end_nxt   = cand_end[END_W-1:0];
        slot_nxt  = 6'(count_r[IDX_W-1:0]);
        mem_we    = 1'b1;
        mem_wa    = count_r[IDX_W-1:0];
        mem_wd    = {cand_r[MIN_W-1:0], dur_r};
      end
      OUT_CHANGE: begin
        start_nxt = ob;
        end_nxt   = chg_write ? (END_W'(ob) + END_W'(dur_r)) : oe;
        slot_nxt  = 6'(ptr_r);
        mem_we    = chg_write;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_r <= mem[ptr_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= (ctl.kind != OUT_NONE);
    end
  end

  always_ff @(posedge clk) begin
    ptr_r   <= ptr_nxt;
    clean_r <= clean_nxt;
    cand_r  <= cand_nxt;
    if (ctl.load) begin
      dur_r <= in_item.duration;
    end
    if (ctl.kind != OUT_NONE) begin
      status_r <= ctl.status;
      start_r  <= start_nxt;
      end_r    <= end_nxt;
      slot_r   <= slot_nxt;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    out_result.status         = status_r;
    out_result.start_minute   = start_r;
    out_result.end_minute     = end_r;
    out_result.slot_number    = slot_r;
    out_result.count_now      = CNT_OUT_W'(count_r);
    out_result.total_reserved = sum_r;
  end

endmodule

// ===== hdl/first_fit_interval_reserver_unit.sv =====
// Top level of the first-fit interval reserver: controller plus datapath.
//
//   channel  handshake           payload
//   input    start / busy        in_item (command, duration, entry_index)
//   result   out_valid strobe    out_result (status .. total_reserved)
//   config   cfg_we              cfg_index, cfg_data
//
// Clear, unused and rejected commands give their result one cycle after the transaction.
// A change reads the entry first and then answers from the change state.
// A reserve compares the candidate with one stored entry per cycle and moves the candidate
// one step per cycle on an overlap.
// Reset (rst_n low at a clock edge) empties the table and loads default window settings.
// The result strobe lasts one cycle; the receiver cannot stall it.
module first_fit_interval_reserver_unit import ffir_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_item,
  output logic                  out_valid,
  output out_result_t           out_result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctl_cmd_t ctl;
  dp_sts_t  sts;

  ffir_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  ffir_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_item    (in_item),
    .ctl        (ctl),
    .sts        (sts),
    .out_result (out_result),
    .out_valid  (out_valid)
  );

endmodule
